// ===== rtl/core/gcse_pkg.sv =====
// gcse_pkg: types, constants and codes of the grid cell store engine
// no dependencies; imported by gcse_datapath, gcse_ctrl and the top level
package gcse_pkg;

   localparam int MAX_COLS   = 64;
   localparam int MAX_ROWS   = 64;
   localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CELL_W     = 64;
   localparam int DIM_W      = 7;
   localparam int COORD_W    = 6;
   localparam int COUNT_W    = 13;
   localparam int CSR_IDX_W  = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [2:0] {
      OP_GET     = 3'd0,
      OP_SET     = 3'd1,
      OP_FILL    = 3'd2,
      OP_COUNT   = 3'd3,
      OP_FIND    = 3'd4,
      OP_REPLACE = 3'd5
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_COLUMNS = 2'd0,
      CSR_GRID_ROWS    = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_POINT,
      ST_ACCESS,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [15:0] col;
      logic signed [15:0] row;
      logic signed [63:0] value;
      logic signed [63:0] repl_value;
   } req_word_type;

   typedef struct packed {
      logic signed [63:0]   read_value;
      logic                 hit;
      logic [COUNT_W-1:0]   match_count;
      logic [COORD_W-1:0]   found_col;
      logic [COORD_W-1:0]   found_row;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic point;
      logic access;
      logic scan_step;
      logic clear_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic clear_last;
   } status_type;

endpackage

// ===== rtl/core/gcse_ram.sv =====
// gcse_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module gcse_ram #(
   parameter int   WIDTH  = 64,
   parameter int   DEPTH  = 4096,
   localparam int  AddrW  = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/gcse_datapath.sv =====
// gcse_datapath: request and config registers, cell store, scan counters, result register
// depends on gcse_pkg and gcse_ram
module gcse_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  gcse_pkg::cmd_type              cmd,
   output gcse_pkg::status_type           status,
   input  gcse_pkg::req_word_type         req_word,
   output gcse_pkg::rsp_word_type         rsp_word,
   input  logic                           csr_write,
   input  logic [gcse_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gcse_pkg::DIM_W-1:0]     csr_data
);
   import gcse_pkg::*;

   req_word_type       req_ff;
   logic [DIM_W-1:0]   cols_ff, rows_ff;
   logic [DIM_W-1:0]   eff_cols, eff_rows;
   logic [COORD_W-1:0] last_col, last_row;

   logic               point_hit_ff, point_hit_in;
   logic [ADDR_W-1:0]  point_addr_ff, point_addr_in;
   logic [12:0]        point_prod;

   logic [ADDR_W-1:0]  scan_addr_ff;
   logic [COORD_W-1:0] scan_col_ff, scan_row_ff;
   logic               pend_valid_ff;
   logic [ADDR_W-1:0]  pend_addr_ff;
   logic [COORD_W-1:0] pend_col_ff, pend_row_ff;

   logic [COUNT_W-1:0] count_ff;
   logic               found_ff;
   logic [COORD_W-1:0] found_col_ff, found_row_ff;

   logic               is_get, is_set, is_fill, is_compare, is_find, is_replace;
   logic               match;

   logic               wr_en, rd_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [CELL_W-1:0]  wr_data, rd_data;

   rsp_word_type       rsp_ff, rsp_in;

   // clamped dimensions
   always_comb begin
      eff_cols = cols_ff;
      if (cols_ff == '0) begin
         eff_cols = DIM_W'(1);
      end else if (cols_ff > DIM_W'(MAX_COLS)) begin
         eff_cols = DIM_W'(MAX_COLS);
      end
      eff_rows = rows_ff;
      if (rows_ff == '0) begin
         eff_rows = DIM_W'(1);
      end else if (rows_ff > DIM_W'(MAX_ROWS)) begin
         eff_rows = DIM_W'(MAX_ROWS);
      end
   end

   assign last_col = COORD_W'(eff_cols - DIM_W'(1));
   assign last_row = COORD_W'(eff_rows - DIM_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= DIM_W'(MAX_COLS);
         rows_ff <= DIM_W'(MAX_ROWS);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_GRID_COLUMNS: cols_ff <= csr_data;
            CSR_GRID_ROWS:    rows_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
      end
   end

   assign is_get     = (req_ff.opcode == OP_GET);
   assign is_set     = (req_ff.opcode == OP_SET);
   assign is_fill    = (req_ff.opcode == OP_FILL);
   assign is_find    = (req_ff.opcode == OP_FIND);
   assign is_replace = (req_ff.opcode == OP_REPLACE);
   assign is_compare = (req_ff.opcode == OP_COUNT) || is_find || is_replace;

   // single cell address
   assign point_hit_in = !req_ff.col[15] && !req_ff.row[15]
                      && (req_ff.col[14:0] < 15'(eff_cols))
                      && (req_ff.row[14:0] < 15'(eff_rows));
   assign point_prod    = 13'(req_ff.row[COORD_W-1:0]) * 13'(eff_cols);
   assign point_addr_in = ADDR_W'(point_prod + 13'(req_ff.col[COORD_W-1:0]));

   always_ff @(posedge clock) begin
      if (cmd.point) begin
         point_hit_ff  <= point_hit_in;
         point_addr_ff <= point_addr_in;
      end
   end

   // scan and clear counters
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff  <= '0;
         scan_col_ff   <= '0;
         scan_row_ff   <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= cmd.scan_step;
         if (cmd.load) begin
            scan_addr_ff <= '0;
            scan_col_ff  <= '0;
            scan_row_ff  <= '0;
         end else if (cmd.scan_step) begin
            scan_addr_ff <= scan_addr_ff + ADDR_W'(1);
            if (scan_col_ff == last_col) begin
               scan_col_ff <= '0;
               scan_row_ff <= scan_row_ff + COORD_W'(1);
            end else begin
               scan_col_ff <= scan_col_ff + COORD_W'(1);
            end
         end else if (cmd.clear_step) begin
            scan_addr_ff <= scan_addr_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step) begin
         pend_addr_ff <= scan_addr_ff;
         pend_col_ff  <= scan_col_ff;
         pend_row_ff  <= scan_row_ff;
      end
   end

   assign status.scan_last  = (scan_col_ff == last_col) && (scan_row_ff == last_row);
   assign status.clear_last = (scan_addr_ff == ADDR_W'(CELL_COUNT - 1));

   assign match = pend_valid_ff && is_compare && (rd_data == req_ff.value);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         count_ff     <= '0;
         found_ff     <= 1'b0;
         found_col_ff <= '0;
         found_row_ff <= '0;
      end else if (match) begin
         if (count_ff != COUNT_MAX) begin
            count_ff <= count_ff + COUNT_W'(1);
         end
         if (!found_ff) begin
            found_ff     <= 1'b1;
            found_col_ff <= pend_col_ff;
            found_row_ff <= pend_row_ff;
         end
      end
   end

   // store ports
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = scan_addr_ff;
      wr_data = '0;
      if (cmd.clear_step) begin
         wr_en = 1'b1;
      end else if (cmd.scan_step && is_fill) begin
         wr_en   = 1'b1;
         wr_data = req_ff.value;
      end else if (match && is_replace) begin
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff;
         wr_data = req_ff.repl_value;
      end else if (cmd.access && is_set && point_hit_ff) begin
         wr_en   = 1'b1;
         wr_addr = point_addr_ff;
         wr_data = req_ff.value;
      end
   end

   assign rd_en   = (cmd.scan_step && is_compare) || (cmd.access && is_get && point_hit_ff);
   assign rd_addr = cmd.scan_step ? scan_addr_ff : point_addr_ff;

   gcse_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result word
   always_comb begin
      rsp_in = '0;
      case (req_ff.opcode) inside
         OP_GET: begin
            rsp_in.hit = point_hit_ff;
            if (point_hit_ff) begin
               rsp_in.read_value = rd_data;
            end
         end
         OP_SET: begin
            rsp_in.hit = point_hit_ff;
         end
         OP_COUNT, OP_REPLACE: begin
            rsp_in.match_count = count_ff;
         end
         OP_FIND: begin
            rsp_in.hit       = found_ff;
            rsp_in.found_col = found_col_ff;
            rsp_in.found_row = found_row_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

// ===== rtl/core/gcse_ctrl.sv =====
// gcse_ctrl: controller state machine sequencing clear, single access and scans
// depends on gcse_pkg
module gcse_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [2:0]           req_opcode,
   output logic                 busy,
   output logic                 rsp_strobe,
   output gcse_pkg::cmd_type    cmd,
   input  gcse_pkg::status_type status
);
   import gcse_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               unique case (req_opcode) inside
                  OP_GET, OP_SET:                       state_in = ST_POINT;
                  OP_FILL, OP_COUNT, OP_FIND, OP_REPLACE: state_in = ST_SCAN;
                  default:                              state_in = ST_FINISH;
               endcase
            end
         end
         ST_POINT:   state_in = ST_ACCESS;
         ST_ACCESS:  state_in = ST_FINISH;
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:   state_in = ST_FINISH;
         ST_FINISH:  state_in = ST_RESPOND;
         ST_RESPOND: state_in = ST_IDLE;
         default:    state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_CLEAR:   cmd.clear_step = 1'b1;
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_POINT:   cmd.point     = 1'b1;
         ST_ACCESS:  cmd.access    = 1'b1;
         ST_SCAN:    cmd.scan_step = 1'b1;
         ST_DRAIN:   ;
         ST_FINISH:  cmd.finish    = 1'b1;
         ST_RESPOND: rsp_strobe    = 1'b1;
         default:    ;
      endcase
   end

`ifndef ASSERT_OFF
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not make the block busy");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("block not idle after delivering a result");

   a_finish_strobe: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_strobe)
      else $error("latched result not delivered");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.point, cmd.access, cmd.scan_step, cmd.clear_step, cmd.finish}))
      else $error("conflicting datapath commands");
`endif

endmodule

// ===== rtl/core/grid_cell_store_engine_unit.sv =====
// grid_cell_store_engine_unit: top level of the grid cell store engine
// depends on gcse_pkg, gcse_ctrl, gcse_datapath (which holds gcse_ram)
//
// One word is taken when start is high and busy is low; exactly one result
// word follows on rsp_word with a one-cycle rsp_strobe, which the receiver
// must take since it cannot stall the block. After reset the 4096-cell store
// is swept to zero one cell per cycle, busy staying high until the sweep ends. Get and
// set step through point, access, finish and respond; unused opcodes through
// finish and respond; fill, count, find and replace through scan, drain,
// finish and respond, the scan walking the cells in use through the store's
// separate write and read ports, one cell per cycle. Configuration writes are
// always accepted (csr_ready stays high) and belong in idle periods; the
// dimensions act as 1 when written as 0 and saturate at 64.
module grid_cell_store_engine_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  gcse_pkg::req_word_type         req_word,
   output logic                           rsp_strobe,
   output gcse_pkg::rsp_word_type         rsp_word,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gcse_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gcse_pkg::DIM_W-1:0]     csr_data
);
   import gcse_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   gcse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_word.opcode),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   gcse_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_word  (req_word),
      .rsp_word  (rsp_word),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule
